@@ rtl/chfd_pkg.sv @@
// Shared types and constants for the CRC-checked humidity frame decoder.
package chfd_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    localparam logic [14:0] TEMP_SPAN_CENTI   = 15'd17500;
    localparam logic [13:0] HUMID_SPAN_CENTI  = 14'd10000;
    localparam logic [15:0] TEMP_OFFSET_CENTI = 16'd4500;
    localparam logic [15:0] RAW_FULL_SCALE    = 16'hFFFF;

    // Byte positions within a frame
    localparam logic [2:0] POS_TEMP_HI  = 3'd0;
    localparam logic [2:0] POS_TEMP_LO  = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUM_HI   = 3'd3;
    localparam logic [2:0] POS_HUM_LO   = 3'd4;
    localparam logic [2:0] POS_HUM_CRC  = 3'd5;

    // CRC status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_TEMP_BAD  = 2'd1;
    localparam logic [1:0] STAT_HUMID_BAD = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic [1:0]         crc_status;
    } t_out_item;

    // One complete frame handed from front to back
    typedef struct packed {
        logic [15:0] temp_raw;
        logic [15:0] humid_raw;
        logic [1:0]  crc_status;
    } t_frame;

endpackage

@@ rtl/crc_checked_humidity_frame_decoder.sv @@
// Top level of the CRC-checked humidity frame decoder.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_ready    i_in_item  (rx_byte, frame_start)
//   out      output     o_out_valid / i_out_ready  o_out_item (temperature, humidity, status)
//
// One byte per cycle is accepted while the frame queue has room.
// After the sixth byte a frame passes the queue, the multiply register and the divide-by-65535 output register.
// The front end takes bytes while the back end stalls, until QUEUE_DEPTH frames wait.
// Synchronous active-low reset clears position, raw words and all valid flags and sets the CRC to CRC_INIT.
module crc_checked_humidity_frame_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  chfd_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output chfd_pkg::t_out_item o_out_item
);
    import chfd_pkg::*;

    logic   accept;
    logic   push;
    logic   q_full;
    logic   q_nonempty;
    logic   pop;
    t_frame front_frame;
    t_frame q_frame;

    // Hold input while the queue is full; a sixth byte could not be stored
    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && o_in_ready;

    chfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_push   (push),
        .o_frame  (front_frame)
    );

    chfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_frame    (front_frame),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_frame    (q_frame)
    );

    chfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_nonempty),
        .i_frame (q_frame),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

@@ rtl/chfd_front.sv @@
// Front end: tracks byte position, runs the CRC and assembles frames.
module chfd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  chfd_pkg::t_in_item i_item,
    output logic            o_push,
    output chfd_pkg::t_frame o_frame
);
    import chfd_pkg::*;

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_temp_raw, n_temp_raw;
    logic [15:0] r_humid_raw, n_humid_raw;
    logic        r_temp_bad, n_temp_bad;
    logic [2:0]  pos;
    logic [7:0]  crc_base;
    logic [7:0]  crc_fed;

    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    always_comb begin
        // A frame start or an impossible position restarts the frame
        if (i_item.frame_start || r_pos > POS_HUM_CRC) begin
            pos      = POS_TEMP_HI;
            crc_base = CRC_INIT;
        end else begin
            pos      = r_pos;
            crc_base = r_crc;
        end
        crc_fed = crc_feed(crc_base, i_item.rx_byte);
    end

    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_temp_raw  = r_temp_raw;
        n_humid_raw = r_humid_raw;
        n_temp_bad  = r_temp_bad;
        o_push      = 1'b0;
        if (i_accept) begin
            n_pos = (pos >= POS_HUM_CRC) ? POS_TEMP_HI : pos + 3'd1;
            case (pos)
                POS_TEMP_HI: begin
                    n_crc      = crc_fed;
                    n_temp_raw = {i_item.rx_byte, r_temp_raw[7:0]};
                end
                POS_TEMP_LO: begin
                    n_crc      = crc_fed;
                    n_temp_raw = {r_temp_raw[15:8], i_item.rx_byte};
                end
                POS_TEMP_CRC: begin
                    n_temp_bad = (crc_base != i_item.rx_byte);
                    n_crc      = CRC_INIT;
                end
                POS_HUM_HI: begin
                    n_crc       = crc_fed;
                    n_humid_raw = {i_item.rx_byte, r_humid_raw[7:0]};
                end
                POS_HUM_LO: begin
                    n_crc       = crc_fed;
                    n_humid_raw = {r_humid_raw[15:8], i_item.rx_byte};
                end
                default: begin
                    n_crc  = CRC_INIT;
                    o_push = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_frame.temp_raw  = r_temp_raw;
        o_frame.humid_raw = r_humid_raw;
        if (r_temp_bad) begin
            o_frame.crc_status = STAT_TEMP_BAD;
        end else if (crc_base != i_item.rx_byte) begin
            o_frame.crc_status = STAT_HUMID_BAD;
        end else begin
            o_frame.crc_status = STAT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_TEMP_HI;
            r_crc       <= CRC_INIT;
            r_temp_raw  <= '0;
            r_humid_raw <= '0;
            r_temp_bad  <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_temp_raw  <= n_temp_raw;
            r_humid_raw <= n_humid_raw;
            r_temp_bad  <= n_temp_bad;
        end
    end

endmodule

@@ rtl/chfd_queue.sv @@
// Short frame queue between the front end and the scaling back end.
module chfd_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  chfd_pkg::t_frame i_frame,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_nonempty,
    output chfd_pkg::t_frame o_frame
);
    import chfd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_frame        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_frame    = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        n_count = r_count + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ rtl/chfd_back.sv @@
// Back end: scales raw words to centi-units in a two-stage pipeline.
module chfd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  chfd_pkg::t_frame  i_frame,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output chfd_pkg::t_out_item o_item
);
    import chfd_pkg::*;

    logic        r_a_vld;
    logic [30:0] r_t_prod;
    logic [29:0] r_h_prod;
    logic [1:0]  r_a_status;
    logic        r_o_vld;
    t_out_item   r_o_item, n_o_item;
    logic        a_en;
    logic        o_en;
    logic [15:0] t_quot;
    logic [15:0] h_quot;
    logic [15:0] temp_s;

    // floor(x / 65535) for x < 2^31: x = q*65535 + (q + r), and q + r < 2*65535
    function automatic logic [15:0] div_full_scale(input logic [30:0] x);
        logic [14:0] q;
        logic [16:0] s;
        q = x[30:16];
        s = {2'b00, q} + {1'b0, x[15:0]};
        return {1'b0, q} + ((s >= {1'b0, RAW_FULL_SCALE}) ? 16'd1 : 16'd0);
    endfunction

    assign o_en    = !r_o_vld || i_ready;
    assign a_en    = !r_a_vld || o_en;
    assign o_pop   = i_valid && a_en;
    assign o_valid = r_o_vld;
    assign o_item  = r_o_item;

    always_comb begin
        t_quot = div_full_scale(r_t_prod);
        h_quot = div_full_scale({1'b0, r_h_prod});
        temp_s = t_quot - TEMP_OFFSET_CENTI;
        n_o_item.temperature_centi = $signed(temp_s[14:0]);
        n_o_item.humidity_centi    = h_quot[13:0];
        n_o_item.crc_status        = r_a_status;
    end

    always_ff @(posedge i_clk) begin
        if (a_en) begin
            r_t_prod   <= 31'(TEMP_SPAN_CENTI * i_frame.temp_raw);
            r_h_prod   <= 30'(HUMID_SPAN_CENTI * i_frame.humid_raw);
            r_a_status <= i_frame.crc_status;
        end
        if (o_en) begin
            r_o_item <= n_o_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (a_en) begin
                r_a_vld <= i_valid;
            end
            if (o_en) begin
                r_o_vld <= r_a_vld;
            end
        end
    end

endmodule
